// ===== src/acls_pkg.sv =====
// Shared types, codes and constants of the AFC channel lock search block.
`default_nettype none
package acls_pkg;

	localparam int unsigned FREQ_W = 16;
	localparam int unsigned CNT_W = 8;
	localparam int unsigned FLAG_W = 5;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned S_TDATA_W = 32;
	localparam int unsigned M_TDATA_W = 40;

	localparam logic OP_START = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_FM_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TV_MIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TV_MAX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FM_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FM_MAX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_WIN = 3'd5;

	localparam logic [1:0] OUTCOME_STOP = 2'd0;
	localparam logic [1:0] OUTCOME_NOT_FOUND = 2'd1;
	localparam logic [1:0] OUTCOME_FOUND = 2'd2;

	localparam logic [1:0] DET_NONE = 2'd0;
	localparam logic [1:0] DET_SIGNAL = 2'd1;

	localparam logic [3:0] AFC_CENTER_LOW = 4'd0;
	localparam logic [3:0] AFC_EDGE_HIGH = 4'd7;
	localparam logic [3:0] AFC_EDGE_LOW = 4'd8;
	localparam logic [3:0] AFC_CENTER_HIGH = 4'd15;

	localparam logic [7:0] AFC_LOCK_MASK = 8'h50;

	localparam logic [FLAG_W-1:0] FLAG_RESTART = 5'h01;
	localparam logic [FLAG_W-1:0] FLAG_EDGE = 5'h02;
	localparam logic [FLAG_W-1:0] FLAG_CENTER = 5'h04;
	localparam logic [FLAG_W-1:0] FLAG_NEAR = 5'h0a;
	localparam logic [FLAG_W-1:0] FLAG_OFF = 5'h10;
	localparam logic [FLAG_W-1:0] FLAGS_FM_LOCK = 5'h0f;
	localparam logic [FLAG_W-1:0] FLAGS_TV_LOCK = 5'h1f;
	localparam logic [FLAG_W-1:0] FLAGS_WEAK_A = 5'h1b;
	localparam logic [FLAG_W-1:0] FLAGS_WEAK_B = 5'h1a;

	localparam logic [CNT_W-1:0] WEAK_MIN = 8'd4;
	localparam logic [CNT_W-1:0] EDGE_MIN_UP = 8'd3;
	localparam logic [CNT_W-1:0] EDGE_MIN_DOWN = 8'd0;

	localparam logic [FREQ_W-1:0] TV_MIN_RESET = 16'd0;
	localparam logic [FREQ_W-1:0] TV_MAX_RESET = 16'hffff;
	localparam logic [FREQ_W-1:0] FM_MIN_RESET = 16'd0;
	localparam logic [FREQ_W-1:0] FM_MAX_RESET = 16'hffff;
	localparam logic [FREQ_W-1:0] STOP_WIN_RESET = 16'd300;

	typedef struct packed {
		logic fm_mode;
		logic [FREQ_W-1:0] tv_min_freq;
		logic [FREQ_W-1:0] tv_max_freq;
		logic [FREQ_W-1:0] fm_min_freq;
		logic [FREQ_W-1:0] fm_max_freq;
		logic [FREQ_W-1:0] stop_window;
	} cfg_t;

	typedef struct packed {
		logic [FREQ_W-1:0] current_step;
		logic [FREQ_W-1:0] base_step;
		logic direction_up;
		logic [FLAG_W-1:0] afc_flags;
		logic [CNT_W-1:0] edge_count;
		logic [CNT_W-1:0] weak_count;
		logic [FREQ_W-1:0] candidate_step;
		logic busy;
	} state_t;

	typedef struct packed {
		logic [FREQ_W-1:0] found_freq;
		logic [1:0] outcome;
		logic done_res;
		logic [FREQ_W-1:0] tune_freq;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage
`default_nettype wire

// ===== src/acls_step.sv =====
// Next-state and result logic for one start or reading item of the channel search.
`default_nettype none
module acls_step (
	input  acls_pkg::state_t st,
	input  acls_pkg::cfg_t cfg,
	input  logic operation,
	input  logic [15:0] start_freq,
	input  logic search_up,
	input  logic [7:0] afc_status,
	input  logic stop_request,
	input  logic [1:0] signal_detect,
	output acls_pkg::state_t nxt,
	output acls_pkg::result_t res
);

	logic signed [17:0] cur;
	logic signed [17:0] nxt_cur;
	logic signed [17:0] lo;
	logic signed [17:0] hi;
	logic [16:0] win_hi;
	logic [16:0] win_lo;
	logic beyond;
	logic up;
	logic fm;
	logic found;
	logic edge_ok;
	logic [acls_pkg::FLAG_W-1:0] f;

	assign up = st.direction_up;
	assign fm = cfg.fm_mode;
	assign win_hi = {1'b0, st.base_step} + {1'b0, cfg.stop_window};
	assign win_lo = {1'b0, st.base_step} - {1'b0, cfg.stop_window};
	assign beyond = up ? ({1'b0, st.current_step} > win_hi)
		: (!win_lo[16] && (st.current_step < win_lo[15:0]));
	assign lo = signed'({2'b00, fm ? cfg.fm_min_freq : cfg.tv_min_freq});
	assign hi = signed'({2'b00, fm ? cfg.fm_max_freq : cfg.tv_max_freq});

	always_comb begin
		nxt = st;
		res.tune_freq = st.current_step;
		res.done_res = 1'b0;
		res.outcome = acls_pkg::OUTCOME_STOP;
		res.found_freq = '0;
		cur = signed'({2'b00, st.current_step});
		nxt_cur = cur;
		f = st.afc_flags;
		found = 1'b0;
		edge_ok = 1'b0;
		if (operation == acls_pkg::OP_START) begin
			nxt.current_step = start_freq;
			nxt.base_step = start_freq;
			nxt.direction_up = search_up;
			nxt.afc_flags = '0;
			nxt.edge_count = '0;
			nxt.weak_count = '0;
			nxt.candidate_step = '0;
			nxt.busy = 1'b1;
			res.tune_freq = start_freq;
		end else if (!st.busy) begin
			nxt = st;
		end else if (stop_request && beyond) begin
			nxt.busy = 1'b0;
			res.done_res = 1'b1;
		end else begin
			case (afc_status[3:0])
				acls_pkg::AFC_EDGE_HIGH: begin
					if (up) begin
						f = acls_pkg::FLAG_RESTART;
						if (!fm) begin
							cur = cur + 18'sd1;
						end
					end else begin
						nxt.edge_count = acls_pkg::sat_inc(st.edge_count);
						f = f | acls_pkg::FLAG_EDGE;
					end
				end
				acls_pkg::AFC_EDGE_LOW: begin
					if (up) begin
						nxt.edge_count = acls_pkg::sat_inc(st.edge_count);
						f = f | acls_pkg::FLAG_EDGE;
					end else begin
						f = acls_pkg::FLAG_RESTART;
						if (!fm) begin
							cur = cur - 18'sd1;
						end
					end
				end
				acls_pkg::AFC_CENTER_LOW, acls_pkg::AFC_CENTER_HIGH: begin
					f = f | acls_pkg::FLAG_CENTER;
					nxt.candidate_step = cur[15:0];
				end
				default: begin
					if (afc_status[3:0] > acls_pkg::AFC_EDGE_LOW) begin
						f = f | acls_pkg::FLAG_OFF;
					end else begin
						f = f | acls_pkg::FLAG_NEAR;
					end
				end
			endcase

			if (fm) begin
				found = (f == acls_pkg::FLAGS_FM_LOCK);
			end else begin
				if (f == acls_pkg::FLAGS_WEAK_A || f == acls_pkg::FLAGS_WEAK_B) begin
					nxt.weak_count = acls_pkg::sat_inc(st.weak_count);
					if (nxt.candidate_step == '0) begin
						nxt.candidate_step = cur[15:0];
					end
				end else begin
					nxt.weak_count = '0;
				end
				edge_ok = up ? (nxt.edge_count > acls_pkg::EDGE_MIN_UP)
					: (nxt.edge_count > acls_pkg::EDGE_MIN_DOWN);
				if ((afc_status & acls_pkg::AFC_LOCK_MASK) != acls_pkg::AFC_LOCK_MASK) begin
					f = '0;
					nxt.edge_count = '0;
				end else if ((f == acls_pkg::FLAGS_TV_LOCK
					|| nxt.weak_count > acls_pkg::WEAK_MIN) && edge_ok) begin
					if (signal_detect == acls_pkg::DET_SIGNAL) begin
						found = 1'b1;
					end else begin
						if (signal_detect == acls_pkg::DET_NONE) begin
							nxt.weak_count = '0;
							f = '0;
							nxt.edge_count = '0;
						end
						nxt.candidate_step = '0;
					end
				end
			end

			nxt.afc_flags = f;
			if (found) begin
				nxt.busy = 1'b0;
				res.tune_freq = nxt.candidate_step;
				res.done_res = 1'b1;
				res.outcome = acls_pkg::OUTCOME_FOUND;
				res.found_freq = nxt.candidate_step;
			end else begin
				nxt_cur = up ? cur + 18'sd1 : cur - 18'sd1;
				if (up ? (nxt_cur > hi) : (nxt_cur < lo)) begin
					nxt.busy = 1'b0;
					res.done_res = 1'b1;
					res.outcome = acls_pkg::OUTCOME_NOT_FOUND;
				end else begin
					nxt.current_step = nxt_cur[15:0];
					res.tune_freq = nxt_cur[15:0];
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/afc_channel_lock_search.sv =====
// Top level of the AFC channel lock search sequencer with stream ports and config port.
// A result is registered and shows on the master side the cycle after its input transfer.
// One item per cycle when not stalled; search state and result register update together.
// The result register frees in the cycle its transfer completes, so input is taken then too.
// Reset clears the search state to idle and loads the configuration register defaults.
`default_nettype none
module afc_channel_lock_search (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// From bit 0: start_freq[15:0], search_up, afc_status[7:0], stop_request,
	// signal_detect[1:0], zero fill.
	input  logic [acls_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// Bit 0: operation.
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// From bit 0: tune_freq[15:0], done_res, outcome[1:0], found_freq[15:0], zero fill.
	output logic [acls_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input  logic cfg_we,
	input  logic [acls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [acls_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	acls_pkg::cfg_t cfg_q;
	acls_pkg::state_t state_q;
	acls_pkg::state_t state_nxt;
	acls_pkg::result_t res_nxt;
	acls_pkg::result_t res_q;
	logic out_valid_q;
	logic in_xfer;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(acls_pkg::M_TDATA_W - $bits(acls_pkg::result_t)){1'b0}}, res_q};

	acls_step u_step (
		.st(state_q),
		.cfg(cfg_q),
		.operation(s_axis_tuser),
		.start_freq(s_axis_tdata[15:0]),
		.search_up(s_axis_tdata[16]),
		.afc_status(s_axis_tdata[24:17]),
		.stop_request(s_axis_tdata[25]),
		.signal_detect(s_axis_tdata[27:26]),
		.nxt(state_nxt),
		.res(res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fm_mode <= 1'b0;
			cfg_q.tv_min_freq <= acls_pkg::TV_MIN_RESET;
			cfg_q.tv_max_freq <= acls_pkg::TV_MAX_RESET;
			cfg_q.fm_min_freq <= acls_pkg::FM_MIN_RESET;
			cfg_q.fm_max_freq <= acls_pkg::FM_MAX_RESET;
			cfg_q.stop_window <= acls_pkg::STOP_WIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				acls_pkg::CFG_FM_MODE: cfg_q.fm_mode <= cfg_wdata[0];
				acls_pkg::CFG_TV_MIN: cfg_q.tv_min_freq <= cfg_wdata;
				acls_pkg::CFG_TV_MAX: cfg_q.tv_max_freq <= cfg_wdata;
				acls_pkg::CFG_FM_MIN: cfg_q.fm_min_freq <= cfg_wdata;
				acls_pkg::CFG_FM_MAX: cfg_q.fm_max_freq <= cfg_wdata;
				acls_pkg::CFG_STOP_WIN: cfg_q.stop_window <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			state_q <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q <= res_nxt;
		end
	end

	a_start_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_axis_tuser == acls_pkg::OP_START) |=> state_q.busy)
		else $error("start transfer did not make the search busy");

	a_done_clears_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && res_nxt.done_res) |=> (!state_q.busy && res_q.done_res))
		else $error("ended search still busy");

	a_outcome_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.done_res) |-> (res_q.outcome == acls_pkg::OUTCOME_STOP))
		else $error("outcome set on a result that does not end the search");

	a_found_freq_only_when_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.outcome != acls_pkg::OUTCOME_FOUND) |-> (res_q.found_freq == '0))
		else $error("found frequency reported without a found outcome");

	a_idle_reading_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_axis_tuser == acls_pkg::OP_READ && !state_q.busy)
		|=> (state_q == $past(state_q)))
		else $error("reading while idle changed the search state");

endmodule
`default_nettype wire
